// ----- rtl/assert_macros.svh -----
// Assertion macros used by the duplicate entry filter RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DEDUP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dedup assertion failed");
`define DEDUP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dedup assertion failed");
`else
`define DEDUP_ASSERT(lbl, clk, rst_n, prop)
`define DEDUP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/dedup_pkg.sv -----
// Package for the duplicate entry filter: sizes, search state type, result struct and saturating increment.
// No dependencies.
package dedup_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SCNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 64;
  localparam int MOVE_W      = 16;
  localparam int DATA_W      = 16;
  localparam int CNT_W       = 32;
  localparam int ENTRY_W     = KEY_W + MOVE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } search_state_t;

  // Outcome of one table search, handed from the search unit to the counters.
  typedef struct packed {
    logic valid;
    logic hit;
    logic store;
    logic overflow;
  } search_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/duplicate_entry_filter_core.sv -----
// Top level of the duplicate entry filter: request capture, search, counters, result register.
// Depends on dedup_pkg, dedup_ram, dedup_search and dedup_cnt.
//
// Usage: a request (key, move, count, learn, first-of-run flag) enters on the in_ channel
// with valid/ready. The key and move are searched in a table of unique entries held in a
// 1024 x 80 bit synchronous RAM, one stored entry read per cycle. A miss is appended to
// the table and reported with out_is_new; a miss into a full table reports
// out_table_overflow instead. Every request gives exactly one result on the out_ channel,
// carrying the request fields and the saturating run counters after this request.
// A request with first_of_run set empties the table and zeroes the counters first.
// Timing: with n entries stored, a request that misses reads all n entries before its
// result is ready; a hit at table place i ends the scan once that entry has been read
// and compared. The scan of the RAM, one read port at one read a cycle, sets the search
// time. One request is in the search at a time.
// Stalls: the result sits in an output register; while it waits, the next request is
// accepted and searched, and its search holds at its end until the register frees.
// Reset empties the table (no clearing pass is needed, only the stored count is cleared),
// zeroes the counters and drops out_valid.
module duplicate_entry_filter_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_first_of_run,
  input  logic [dedup_pkg::KEY_W-1:0]          in_entry_key,
  input  logic [dedup_pkg::MOVE_W-1:0]         in_entry_move,
  input  logic [dedup_pkg::DATA_W-1:0]         in_entry_count,
  input  logic [dedup_pkg::DATA_W-1:0]         in_entry_learn,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_is_new,
  output logic                                 out_table_overflow,
  output logic [dedup_pkg::KEY_W-1:0]          out_key,
  output logic [dedup_pkg::MOVE_W-1:0]         out_move,
  output logic [dedup_pkg::DATA_W-1:0]         out_count,
  output logic [dedup_pkg::DATA_W-1:0]         out_learn,
  output logic [dedup_pkg::CNT_W-1:0]          out_total_seen,
  output logic [dedup_pkg::CNT_W-1:0]          out_repeat_seen,
  output logic [dedup_pkg::CNT_W-1:0]          out_unique_seen
);

  // Captured request; held stable for the whole search.
  logic                              first_r;
  logic [dedup_pkg::KEY_W-1:0]       key_r;
  logic [dedup_pkg::MOVE_W-1:0]      move_r;
  logic [dedup_pkg::DATA_W-1:0]      count_r;
  logic [dedup_pkg::DATA_W-1:0]      learn_r;

  logic                              in_acc;
  logic                              res_ready;
  logic                              res_take;
  dedup_pkg::search_res_t            res;

  logic                              rd_en;
  logic [dedup_pkg::IDX_W-1:0]       rd_addr;
  logic [dedup_pkg::ENTRY_W-1:0]     rd_data;
  logic                              wr_en;
  logic [dedup_pkg::IDX_W-1:0]       wr_addr;
  logic [dedup_pkg::ENTRY_W-1:0]     wr_data;

  logic [dedup_pkg::CNT_W-1:0]       total_nxt, repeat_nxt, unique_nxt;

  // Result register.
  logic                              out_valid_r;
  logic                              is_new_r;
  logic                              ovf_r;
  logic [dedup_pkg::KEY_W-1:0]       okey_r;
  logic [dedup_pkg::MOVE_W-1:0]      omove_r;
  logic [dedup_pkg::DATA_W-1:0]      ocount_r;
  logic [dedup_pkg::DATA_W-1:0]      olearn_r;
  logic [dedup_pkg::CNT_W-1:0]       total_r, repeat_r, unique_r;

  assign in_acc    = in_valid && in_ready;
  // The result register can load when empty or when its content leaves this cycle.
  assign res_ready = !out_valid_r || out_ready;
  assign res_take  = res.valid && res_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_r <= in_first_of_run;
      key_r   <= in_entry_key;
      move_r  <= in_entry_move;
      count_r <= in_entry_count;
      learn_r <= in_entry_learn;
    end
  end

  dedup_ram #(
    .DEPTH (dedup_pkg::TABLE_DEPTH),
    .WIDTH (dedup_pkg::ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dedup_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .first     (in_first_of_run),
    .key       (key_r),
    .move      (move_r),
    .res_ready (res_ready),
    .ready     (in_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  dedup_cnt u_cnt (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (res_take),
    .clear      (first_r),
    .res        (res),
    .total_nxt  (total_nxt),
    .repeat_nxt (repeat_nxt),
    .unique_nxt (unique_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      is_new_r <= res.store;
      ovf_r    <= res.overflow;
      okey_r   <= key_r;
      omove_r  <= move_r;
      ocount_r <= count_r;
      olearn_r <= learn_r;
      total_r  <= total_nxt;
      repeat_r <= repeat_nxt;
      unique_r <= unique_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_new         = is_new_r;
  assign out_table_overflow = ovf_r;
  assign out_key            = okey_r;
  assign out_move           = omove_r;
  assign out_count          = ocount_r;
  assign out_learn          = olearn_r;
  assign out_total_seen     = total_r;
  assign out_repeat_seen    = repeat_r;
  assign out_unique_seen    = unique_r;

endmodule

// ----- rtl/dedup_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dedup_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 80,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/dedup_search.sv -----
// Search sequencer: scans the stored entries one read per cycle and appends misses while there is room.
// Depends on dedup_pkg and assert_macros.svh; drives the ports of dedup_ram.
`include "assert_macros.svh"

module dedup_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                first,
  input  logic [dedup_pkg::KEY_W-1:0]         key,
  input  logic [dedup_pkg::MOVE_W-1:0]        move,
  input  logic                                res_ready,
  output logic                                ready,
  output dedup_pkg::search_res_t              res,
  output logic                                rd_en,
  output logic [dedup_pkg::IDX_W-1:0]         rd_addr,
  input  logic [dedup_pkg::ENTRY_W-1:0]       rd_data,
  output logic                                wr_en,
  output logic [dedup_pkg::IDX_W-1:0]         wr_addr,
  output logic [dedup_pkg::ENTRY_W-1:0]       wr_data
);

  dedup_pkg::search_state_t          state_r, state_nxt;
  logic [dedup_pkg::SCNT_W-1:0]      count_r, count_nxt;
  logic [dedup_pkg::SCNT_W-1:0]      idx_r, idx_nxt;
  logic                              pend_r, pend_nxt;
  logic                              hit_r, hit_nxt;
  logic                              room;
  logic                              match;

  assign room  = (count_r < dedup_pkg::SCNT_W'(dedup_pkg::TABLE_DEPTH));
  assign match = pend_r && (rd_data == {key, move});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dedup_pkg::ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    hit_nxt   = hit_r;
    ready     = 1'b0;
    res       = '0;
    rd_en     = 1'b0;
    rd_addr   = idx_r[dedup_pkg::IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = count_r[dedup_pkg::IDX_W-1:0];
    wr_data   = {key, move};
    unique case (state_r)
      dedup_pkg::ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          if (first) begin
            count_nxt = '0;
          end
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = dedup_pkg::ST_SCAN;
        end
      end
      dedup_pkg::ST_SCAN: begin
        // One read is issued per cycle; its data is compared in the next cycle.
        if (match) begin
          hit_nxt   = 1'b1;
          state_nxt = dedup_pkg::ST_FIN;
        end else if (idx_r < count_r) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          state_nxt = dedup_pkg::ST_FIN;
        end
      end
      dedup_pkg::ST_FIN: begin
        res.valid    = 1'b1;
        res.hit      = hit_r;
        res.store    = !hit_r && room;
        res.overflow = !hit_r && !room;
        if (res_ready) begin
          state_nxt = dedup_pkg::ST_IDLE;
          if (!hit_r && room) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = dedup_pkg::ST_IDLE;
      end
    endcase
  end

  `DEDUP_ASSERT(a_count_bound, clk, rst_n,
    count_r <= dedup_pkg::SCNT_W'(dedup_pkg::TABLE_DEPTH))
  `DEDUP_ASSERT(a_write_on_miss, clk, rst_n,
    wr_en |-> (state_r == dedup_pkg::ST_FIN) && !hit_r && res_ready)
  `DEDUP_ASSERT(a_pend_after_read, clk, rst_n,
    (state_r == dedup_pkg::ST_SCAN && pend_r) |-> $past(rd_en))
  `DEDUP_ASSERT(a_store_grows, clk, rst_n,
    wr_en |=> count_r == $past(count_r) + 1'b1)
  `DEDUP_ASSERT_ALWAYS(a_reset_idle, clk,
    !rst_n |=> state_r == dedup_pkg::ST_IDLE)

endmodule

// ----- rtl/dedup_cnt.sv -----
// Saturating run counters for the duplicate entry filter.
// Depends on dedup_pkg.
module dedup_cnt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic                          clear,
  input  dedup_pkg::search_res_t        res,
  output logic [dedup_pkg::CNT_W-1:0]   total_nxt,
  output logic [dedup_pkg::CNT_W-1:0]   repeat_nxt,
  output logic [dedup_pkg::CNT_W-1:0]   unique_nxt
);

  logic [dedup_pkg::CNT_W-1:0] total_r, repeat_r, unique_r;
  logic [dedup_pkg::CNT_W-1:0] total_base, repeat_base, unique_base;

  // A run start zeroes the counters before this entry is counted.
  assign total_base  = clear ? '0 : total_r;
  assign repeat_base = clear ? '0 : repeat_r;
  assign unique_base = clear ? '0 : unique_r;

  always_comb begin
    total_nxt  = total_r;
    repeat_nxt = repeat_r;
    unique_nxt = unique_r;
    if (upd) begin
      total_nxt  = dedup_pkg::sat_inc(total_base);
      repeat_nxt = res.hit ? dedup_pkg::sat_inc(repeat_base) : repeat_base;
      unique_nxt = res.store ? dedup_pkg::sat_inc(unique_base) : unique_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      repeat_r <= '0;
      unique_r <= '0;
    end else begin
      total_r  <= total_nxt;
      repeat_r <= repeat_nxt;
      unique_r <= unique_nxt;
    end
  end

endmodule
